### design/smnp_pkg.sv
`default_nettype none

package smnp_pkg;

    // Accumulator width default; the top level hands it down as a parameter.
    localparam int ACCUM_BITS_DEF = 16;

    // Operation codes carried in the op field of an input word.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_BITS  = 2;
    localparam int         CFG_DATA_BITS = 16;
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_THRESH    = 2'd2;

    // Configuration reset values.
    localparam logic        MODE_RESET    = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
    localparam logic [7:0]  THRESH_RESET  = 8'd2;

    // Strobe phases: high and low nibble of X, then of Y, twice over.
    localparam logic [2:0] PH_XH0 = 3'd0;
    localparam logic [2:0] PH_XL0 = 3'd1;
    localparam logic [2:0] PH_YH0 = 3'd2;
    localparam logic [2:0] PH_YL0 = 3'd3;
    localparam logic [2:0] PH_XH1 = 3'd4;
    localparam logic [2:0] PH_XL1 = 3'd5;
    localparam logic [2:0] PH_YH1 = 3'd6;
    localparam logic [2:0] PH_YL1 = 3'd7;

    localparam int         STROBE_BIT    = 2;
    localparam logic [5:0] STATUS_RESET  = 6'h30;
    localparam logic [3:0] DIR_UP        = 4'h1;
    localparam logic [3:0] DIR_DOWN      = 4'h2;
    localparam logic [3:0] DIR_LEFT      = 4'h4;
    localparam logic [3:0] DIR_RIGHT     = 4'h8;
    localparam logic [7:0] CLAMP_POS     = 8'h7F;
    localparam logic [7:0] CLAMP_NEG     = 8'h81;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [1:0]         press_mask;
        logic [1:0]         release_mask;
        logic [7:0]         write_value;
        logic [31:0]        time_now;
    } t_item;

    // Registered input word handed to the core.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    typedef struct packed {
        logic        mouse_mode;
        logic [15:0] timeout_us;
        logic [7:0]  joy_threshold;
    } t_cfg;

endpackage

`default_nettype wire

### design/smnp_in_if.sv
`default_nettype none

interface smnp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [1:0]         press_mask;
    logic [1:0]         release_mask;
    logic [7:0]         write_value;
    logic [31:0]        time_now;

    modport source (
        output valid, op, delta_x, delta_y, press_mask, release_mask, write_value, time_now,
        input  ready
    );

    modport sink (
        input  valid, op, delta_x, delta_y, press_mask, release_mask, write_value, time_now,
        output ready
    );
endinterface

`default_nettype wire

### design/smnp_out_if.sv
`default_nettype none

interface smnp_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );

    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

`default_nettype wire

### design/strobed_mouse_nibble_port.sv
`default_nettype none

// Strobed mouse nibble port. Input words carry one of three operations: a
// movement/button update (op 0), a port write (op 1) or a port read (op 2);
// op 3 is accepted and has no effect. Only reads return a word on the
// output channel. Updates add deltas into two saturating ACCUM_BITS-wide
// accumulators and clear or set the button bits (release wins over press).
// In mouse mode, writes step the eight-phase strobe sequence on bit 2 of
// the written byte, and a gap longer than timeout_us since the last write
// restarts the sequence; reads return the phase-selected nibble ORed with
// the status bits. In joystick mode, writes are ignored and a read turns
// the accumulated motion into direction bits and clears the accumulators.
// Each word is held in the input register and then processed by the core's
// combinational update logic, so one word is accepted every clock unless a
// read stalls; a read result is written into the result register as the
// core takes its word. The only stall comes
// from the one-entry result register: a read waits while a previous result
// has not been taken. Configuration writes take effect at the next edge
// and are expected only while the block is idle.
module strobed_mouse_nibble_port #(
    parameter int ACCUM_BITS = smnp_pkg::ACCUM_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    smnp_in_if.sink                                  i_in,
    smnp_out_if.source                               o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [smnp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [smnp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import smnp_pkg::*;

    t_cfg   w_cfg;
    t_stage w_stage;
    logic   w_take;

    // Configuration registers.
    smnp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Input register; refills in the same cycle that the core takes its word.
    smnp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    // Port state, the combinational update logic and the result register.
    smnp_core #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_stage (w_stage),
        .o_take  (w_take),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // Every accepted word lands in the input register.
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> w_stage.valid)
        else $error("accepted word not held in the input register");

    // A read that the core processes always produces a result word.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && (w_stage.item.op == OP_READ) |=> o_out.valid)
        else $error("processed read produced no result");

    // The core never processes a word that is not present.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_stage.valid)
        else $error("core took an empty input register");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

### design/smnp_cfg.sv
`default_nettype none

module smnp_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [smnp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [smnp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output smnp_pkg::t_cfg                           o_cfg
);
    import smnp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mouse_mode    <= MODE_RESET;
            r_cfg.timeout_us    <= TIMEOUT_RESET;
            r_cfg.joy_threshold <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:    r_cfg.mouse_mode    <= i_cfg_data[0];
                CFG_TIMEOUT: r_cfg.timeout_us    <= i_cfg_data;
                CFG_THRESH:  r_cfg.joy_threshold <= i_cfg_data[7:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/smnp_in_reg.sv
`default_nettype none

module smnp_in_reg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    smnp_in_if.sink        i_in,
    input  wire logic      i_take,
    output smnp_pkg::t_stage o_stage
);
    import smnp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // The register refills whenever it is empty or its word moves on this cycle.
    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.op           <= i_in.op;
            r_item.delta_x      <= i_in.delta_x;
            r_item.delta_y      <= i_in.delta_y;
            r_item.press_mask   <= i_in.press_mask;
            r_item.release_mask <= i_in.release_mask;
            r_item.write_value  <= i_in.write_value;
            r_item.time_now     <= i_in.time_now;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

`default_nettype wire

### design/smnp_core.sv
`default_nettype none

module smnp_core #(
    parameter int ACCUM_BITS = smnp_pkg::ACCUM_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire smnp_pkg::t_cfg   i_cfg,
    input  wire smnp_pkg::t_stage i_stage,
    output logic                  o_take,
    smnp_out_if.source            o_out
);
    import smnp_pkg::*;

    // Sum width holds any accumulator plus any 16-bit delta without wrapping.
    localparam int SumBits = ((ACCUM_BITS > 16) ? ACCUM_BITS : 16) + 1;

    logic [2:0]                   r_phase, n_phase;
    logic [7:0]                   r_sample_x, n_sample_x;
    logic [7:0]                   r_sample_y, n_sample_y;
    logic signed [ACCUM_BITS-1:0] r_accum_x, n_accum_x;
    logic signed [ACCUM_BITS-1:0] r_accum_y, n_accum_y;
    logic [5:0]                   r_status, n_status;
    logic [31:0]                  r_last_time, n_last_time;
    logic                         r_out_valid;
    logic [5:0]                   r_out_data, n_out_data;

    logic                         w_is_read;
    logic                         w_strobe;
    logic [31:0]                  w_gap;
    logic [2:0]                   w_wr_phase;
    logic [7:0]                   w_clamp_x, w_clamp_y;
    logic [ACCUM_BITS-1:0]        w_abs_x, w_abs_y;
    logic [ACCUM_BITS+3:0]        w_x12, w_y12, w_x5, w_y5;
    logic [ACCUM_BITS-1:0]        w_thresh;
    logic [3:0]                   w_dir;
    logic [3:0]                   w_nibble;

    function automatic logic [ACCUM_BITS-1:0] sat_add(
        input logic [ACCUM_BITS-1:0] a,
        input logic [15:0]           d
    );
        logic [SumBits-1:0] s;
        s = {{(SumBits-ACCUM_BITS){a[ACCUM_BITS-1]}}, a} + {{(SumBits-16){d[15]}}, d};
        // The sum fits when all bits above the result's sign agree with it.
        if ((&s[SumBits-1:ACCUM_BITS-1]) || !(|s[SumBits-1:ACCUM_BITS-1])) begin
            sat_add = s[ACCUM_BITS-1:0];
        end else if (s[SumBits-1]) begin
            sat_add = {1'b1, {(ACCUM_BITS-1){1'b0}}};
        end else begin
            sat_add = {1'b0, {(ACCUM_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic [7:0] clamp127(input logic [ACCUM_BITS-1:0] a);
        logic neg;
        neg = a[ACCUM_BITS-1];
        if (!neg && (|a[ACCUM_BITS-2:7])) begin
            clamp127 = CLAMP_POS;
        end else if (neg && !((&a[ACCUM_BITS-2:7]) && (|a[6:0]))) begin
            clamp127 = CLAMP_NEG;
        end else begin
            clamp127 = a[7:0];
        end
    endfunction

    function automatic logic [ACCUM_BITS-1:0] magnitude(input logic [ACCUM_BITS-1:0] a);
        magnitude = a[ACCUM_BITS-1] ? (~a + 1'b1) : a;
    endfunction

    assign w_is_read = (i_stage.item.op == OP_READ);
    // A read waits only while the result register is full and not drained.
    assign o_take    = i_stage.valid && !(w_is_read && r_out_valid && !o_out.ready);

    assign w_strobe   = i_stage.item.write_value[STROBE_BIT];
    assign w_gap      = i_stage.item.time_now - r_last_time;
    assign w_wr_phase = (w_gap > {16'd0, i_cfg.timeout_us}) ? PH_YL1 : r_phase;
    assign w_clamp_x  = clamp127(r_accum_x);
    assign w_clamp_y  = clamp127(r_accum_y);

    // Joystick direction: 5/12 slope test on the accumulated magnitudes.
    assign w_abs_x  = magnitude(r_accum_x);
    assign w_abs_y  = magnitude(r_accum_y);
    assign w_x12    = {1'b0, w_abs_x, 3'b000} + {2'b00, w_abs_x, 2'b00};
    assign w_y12    = {1'b0, w_abs_y, 3'b000} + {2'b00, w_abs_y, 2'b00};
    assign w_x5     = {2'b00, w_abs_x, 2'b00} + {4'd0, w_abs_x};
    assign w_y5     = {2'b00, w_abs_y, 2'b00} + {4'd0, w_abs_y};
    assign w_thresh = {{(ACCUM_BITS-8){1'b0}}, i_cfg.joy_threshold};

    always_comb begin
        w_dir = 4'd0;
        if (!(w_abs_x < w_thresh && w_abs_y < w_thresh)) begin
            if (w_x12 > w_y5) begin
                w_dir = w_dir | ((!r_accum_x[ACCUM_BITS-1] && (|r_accum_x)) ? DIR_RIGHT
                                                                             : DIR_LEFT);
            end
            if (w_y12 > w_x5) begin
                w_dir = w_dir | ((!r_accum_y[ACCUM_BITS-1] && (|r_accum_y)) ? DIR_DOWN
                                                                             : DIR_UP);
            end
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_XH0, PH_XH1: w_nibble = r_sample_x[7:4];
            PH_XL0, PH_XL1: w_nibble = r_sample_x[3:0];
            PH_YH0, PH_YH1: w_nibble = r_sample_y[7:4];
            default:        w_nibble = r_sample_y[3:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_sample_x  = r_sample_x;
        n_sample_y  = r_sample_y;
        n_accum_x   = r_accum_x;
        n_accum_y   = r_accum_y;
        n_status    = r_status;
        n_last_time = r_last_time;
        n_out_data  = r_out_data;

        unique case (i_stage.item.op)
            OP_UPDATE: begin
                n_accum_x = sat_add(r_accum_x, i_stage.item.delta_x);
                n_accum_y = sat_add(r_accum_y, i_stage.item.delta_y);
                // A release in the same word wins over a press.
                n_status  = (r_status & ~{i_stage.item.press_mask, 4'd0})
                          | {i_stage.item.release_mask, 4'd0};
            end
            OP_WRITE: begin
                if (i_cfg.mouse_mode) begin
                    n_last_time = i_stage.item.time_now;
                    n_phase     = w_wr_phase;
                    unique case (w_wr_phase)
                        PH_XH0, PH_YH0, PH_XH1, PH_YH1: begin
                            if (!w_strobe) begin
                                n_phase = w_wr_phase + 3'd1;
                            end
                        end
                        PH_XL0, PH_XL1: begin
                            if (w_strobe) begin
                                n_phase = w_wr_phase + 3'd1;
                            end
                        end
                        PH_YL0: begin
                            // Alternate cycle: the second pass reports no motion.
                            if (w_strobe) begin
                                n_phase    = PH_XH1;
                                n_sample_x = 8'd0;
                                n_sample_y = 8'd0;
                            end
                        end
                        default: begin
                            if (w_strobe) begin
                                n_phase    = PH_XH0;
                                n_sample_x = w_clamp_x;
                                n_sample_y = w_clamp_y;
                                n_accum_x  = r_accum_x
                                           - {{(ACCUM_BITS-8){w_clamp_x[7]}}, w_clamp_x};
                                n_accum_y  = r_accum_y
                                           - {{(ACCUM_BITS-8){w_clamp_y[7]}}, w_clamp_y};
                            end
                        end
                    endcase
                end
            end
            OP_READ: begin
                if (i_cfg.mouse_mode) begin
                    n_out_data = {r_status[5:4], r_status[3:0] | w_nibble};
                end else begin
                    n_accum_x  = '0;
                    n_accum_y  = '0;
                    n_status   = {r_status[5:4], w_dir};
                    n_out_data = {r_status[5:4], w_dir};
                end
            end
            default: begin
                // Unused operation: the word is consumed with no effect.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_YL1;
            r_sample_x  <= 8'd0;
            r_sample_y  <= 8'd0;
            r_accum_x   <= '0;
            r_accum_y   <= '0;
            r_status    <= STATUS_RESET;
            r_last_time <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase     <= n_phase;
                r_sample_x  <= n_sample_x;
                r_sample_y  <= n_sample_y;
                r_accum_x   <= n_accum_x;
                r_accum_y   <= n_accum_y;
                r_status    <= n_status;
                r_last_time <= n_last_time;
            end
            if (o_take && w_is_read) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_is_read) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;

endmodule

`default_nettype wire

### test/strobed_mouse_nibble_port_tb.sv
`timescale 1ns / 100ps

module strobed_mouse_nibble_port_tb;
    import smnp_pkg::*;

    // The block leaves op 3 unassigned; it is accepted and does nothing.
    localparam logic [1:0] OP_NONE  = 2'd3;
    localparam logic [5:0] BTN_BITS = 6'h30;
    localparam int         ACC_W    = ACCUM_BITS_DEF;

    // One row of the directed part: either a register write or a word. Reads
    // whose answer is obvious carry it typed in; all others use the predictor.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        t_item       w;
        bit          typed;
        logic [5:0]  want;
    } t_row;

    // One setting of the registers for a random phase, plus the idling style.
    typedef struct {
        logic        mode;
        logic [15:0] timeout;
        logic [7:0]  thresh;
        bit          hold;
        bit          quiet;
    } t_setting;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    smnp_in_if  in_if ();
    smnp_out_if out_if ();

    strobed_mouse_nibble_port u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor copy of the register settings.
    logic        port_mode;
    logic [15:0] strobe_timeout;
    logic [7:0]  joy_thresh;

    // Predictor copy of the block state.
    logic [2:0]  port_phase;
    logic [7:0]  samp_x;
    logic [7:0]  samp_y;
    longint      acc_x;
    longint      acc_y;
    logic [5:0]  port_status;
    logic [31:0] last_strobe_time;

    // Read results still owed by the block, oldest first.
    logic [5:0]  pending_reads[$];
    int          err_cnt;

    // The host clock that well-formed strobe sequences follow.
    logic [31:0] now_us;

    // The quiet flag turns all idling off on both sides. The hold flag asks
    // the receiver to refuse results for a long stretch.
    bit quiet;
    bit hold_req;

    t_row     dir_tab[$];
    t_setting plan[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous upper bound on the run; a hang ends here as a failure.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Saturating add into an accumulator of ACC_W signed bits.
    function automatic longint sat_accum(input longint a, input longint d);
        longint hi;
        longint lo;
        longint s;
        hi = (longint'(1) <<< (ACC_W - 1)) - 1;
        lo = -hi - 1;
        s  = a + d;
        if (s > hi) s = hi;
        if (s < lo) s = lo;
        return s;
    endfunction

    function automatic longint clamp127(input longint v);
        if (v > 127) return 127;
        if (v < -127) return -127;
        return v;
    endfunction

    // Advances the predicted state by one accepted word. has_out tells
    // whether the word is a read, and read_val is then its expected answer.
    task automatic predict_word(input t_item w, output bit has_out,
                                output logic [5:0] read_val);
        logic        strobe;
        logic [31:0] gap;
        logic [3:0]  nib;
        longint      ax;
        longint      ay;
        longint      cx;
        longint      cy;
        has_out  = 1'b0;
        read_val = '0;
        case (w.op)
            OP_UPDATE: begin
                acc_x = sat_accum(acc_x, longint'($signed(w.delta_x)));
                acc_y = sat_accum(acc_y, longint'($signed(w.delta_y)));
                // A release on the same word as a press wins for that button.
                port_status = (port_status & ~{w.press_mask, 4'h0}) | {w.release_mask, 4'h0};
            end
            OP_WRITE: begin
                strobe = w.write_value[STROBE_BIT];
                if (port_mode) begin
                    gap = w.time_now - last_strobe_time;
                    if (gap > {16'h0, strobe_timeout}) port_phase = PH_YL1;
                    last_strobe_time = w.time_now;
                    case (port_phase)
                        PH_XH0, PH_YH0, PH_XH1, PH_YH1: begin
                            if (!strobe) port_phase = port_phase + 3'd1;
                        end
                        PH_XL0, PH_XL1: begin
                            if (strobe) port_phase = port_phase + 3'd1;
                        end
                        PH_YL0: begin
                            // The second half of the frame reports zero motion.
                            if (strobe) begin
                                port_phase = PH_XH1;
                                samp_x     = '0;
                                samp_y     = '0;
                            end
                        end
                        default: begin
                            if (strobe) begin
                                cx         = clamp127(acc_x);
                                cy         = clamp127(acc_y);
                                port_phase = PH_XH0;
                                samp_x     = cx[7:0];
                                samp_y     = cy[7:0];
                                acc_x      = acc_x - cx;
                                acc_y      = acc_y - cy;
                            end
                        end
                    endcase
                end
            end
            OP_READ: begin
                has_out = 1'b1;
                if (!port_mode) begin
                    ax = (acc_x > 0) ? acc_x : -acc_x;
                    ay = (acc_y > 0) ? acc_y : -acc_y;
                    port_status = port_status & BTN_BITS;
                    if (!(ax < longint'(joy_thresh) && ay < longint'(joy_thresh))) begin
                        if (12 * ax > 5 * ay)
                            port_status |= {2'b00, (acc_x > 0) ? DIR_RIGHT : DIR_LEFT};
                        if (12 * ay > 5 * ax)
                            port_status |= {2'b00, (acc_y > 0) ? DIR_DOWN : DIR_UP};
                    end
                    acc_x    = 0;
                    acc_y    = 0;
                    read_val = port_status;
                end else begin
                    case (port_phase)
                        PH_XH0, PH_XH1: nib = samp_x[7:4];
                        PH_XL0, PH_XL1: nib = samp_x[3:0];
                        PH_YH0, PH_YH1: nib = samp_y[7:4];
                        default:        nib = samp_y[3:0];
                    endcase
                    // Direction bits left over from joystick mode show up here.
                    read_val = {2'b00, nib} | port_status;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Offers one word from a falling edge, waits for its handshake, and
    // returns at the following falling edge. A typed answer, when given,
    // replaces the predicted one in the list of owed results.
    task automatic push_word(input t_item w, input bit typed, input logic [5:0] want);
        bit         has_out;
        logic [5:0] read_val;
        while (!quiet && $urandom_range(0, 99) < 25) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= w.op;
        in_if.delta_x      <= w.delta_x;
        in_if.delta_y      <= w.delta_y;
        in_if.press_mask   <= w.press_mask;
        in_if.release_mask <= w.release_mask;
        in_if.write_value  <= w.write_value;
        in_if.time_now     <= w.time_now;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_word(w, has_out, read_val);
        if (has_out) pending_reads.push_back(typed ? want : read_val);
        @(negedge i_clk);
    endtask

    // Lets every owed result arrive, then gives words that cause no result
    // time to leave the pipeline, so the block is idle on return.
    task automatic settle_port();
        int guard;
        guard = 0;
        in_if.valid <= 1'b0;
        while (pending_reads.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (6) @(negedge i_clk);
    endtask

    // Drives one register write and mirrors it into the predictor. The
    // caller lowers the write enable after the last one.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MODE:    port_mode      = val[0];
            CFG_TIMEOUT: strobe_timeout = val;
            CFG_THRESH:  joy_thresh     = val[7:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    function automatic t_item make_word(input logic [1:0] op, input int dx, input int dy,
                                        input logic [1:0] pr, input logic [1:0] rl,
                                        input logic [7:0] val, input logic [31:0] t);
        t_item w;
        w.op           = op;
        w.delta_x      = dx[15:0];
        w.delta_y      = dy[15:0];
        w.press_mask   = pr;
        w.release_mask = rl;
        w.write_value  = val;
        w.time_now     = t;
        return w;
    endfunction

    function automatic t_row word_row(input t_item w, input bit typed, input logic [5:0] want);
        t_row r;
        r.is_cfg  = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.w       = w;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [1:0] idx, input logic [15:0] val);
        t_row r;
        r       = word_row('0, 1'b0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // A word with every field random, op 3 included.
    function automatic t_item rand_word();
        t_item w;
        w.op           = 2'($urandom_range(0, 3));
        w.delta_x      = 16'($urandom());
        w.delta_y      = 16'($urandom());
        w.press_mask   = 2'($urandom_range(0, 3));
        w.release_mask = 2'($urandom_range(0, 3));
        w.write_value  = 8'($urandom());
        w.time_now     = $urandom();
        return w;
    endfunction

    // Movement is mostly small so the samples and the slope test see
    // ordinary values; now and then a full-range delta drives saturation.
    function automatic t_item random_update();
        t_item w;
        w    = rand_word();
        w.op = OP_UPDATE;
        if ($urandom_range(0, 9) < 8) begin
            w.delta_x = 16'($signed($urandom_range(0, 400)) - 200);
            w.delta_y = 16'($signed($urandom_range(0, 400)) - 200);
        end
        if ($urandom_range(0, 3) != 0) begin
            w.press_mask   = '0;
            w.release_mask = 2'($urandom_range(0, 3));
        end
        return w;
    endfunction

    // Steps the host clock for the next strobe write. Most gaps stay inside
    // the timeout; a few go just past it or jump far ahead.
    function automatic logic [31:0] next_write_time();
        int unsigned cap;
        int unsigned r;
        cap = (strobe_timeout > 16'd3000) ? 3000 : strobe_timeout;
        r   = $urandom_range(0, 99);
        if (r < 4)
            now_us = now_us + strobe_timeout + 32'd1 + $urandom_range(0, 50);
        else if (r < 6)
            now_us = now_us + $urandom();
        else
            now_us = now_us + $urandom_range(0, cap);
        return now_us;
    endfunction

    // Random traffic until n_items words that the block acts on have gone
    // in. In mouse mode most of it is strobe frames that follow the phase
    // sequence, with reads and updates woven in and an odd wrong strobe.
    task automatic run_random(input int n_items);
        int    done_cnt;
        int    r;
        int    k;
        bit    adv;
        t_item w;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                w = rand_word();
                push_word(w, 1'b0, '0);
                if (w.op != OP_NONE && !(w.op == OP_WRITE && !port_mode)) done_cnt++;
            end else if (port_mode && r < 60) begin
                k = $urandom_range(1, 9);
                repeat (k) begin
                    adv = (port_phase == PH_YL1) || port_phase[0];
                    if ($urandom_range(0, 9) == 0) adv = !adv;
                    w                         = rand_word();
                    w.op                      = OP_WRITE;
                    w.write_value[STROBE_BIT] = adv;
                    w.time_now                = next_write_time();
                    push_word(w, 1'b0, '0);
                    done_cnt++;
                    if ($urandom_range(0, 9) < 7) begin
                        w    = rand_word();
                        w.op = OP_READ;
                        push_word(w, 1'b0, '0);
                        done_cnt++;
                    end
                    if ($urandom_range(0, 9) < 2) begin
                        push_word(random_update(), 1'b0, '0);
                        done_cnt++;
                    end
                end
            end else if (r < (port_mode ? 80 : 60)) begin
                push_word(random_update(), 1'b0, '0);
                done_cnt++;
            end else begin
                w    = rand_word();
                w.op = OP_READ;
                push_word(w, 1'b0, '0);
                done_cnt++;
            end
        end
    endtask

    // Receiver side: ready changes only at falling edges. When a hold is
    // requested, results are refused for a long stretch so the result
    // register fills and the block stops taking words.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_if.ready <= quiet || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Every accepted result is matched against the oldest owed one.
    initial begin
        logic [5:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (pending_reads.size() == 0) begin
                    note_mismatch($sformatf("unexpected read_data 0x%02h", out_if.read_data));
                end else begin
                    want = pending_reads.pop_front();
                    if (out_if.read_data !== want)
                        note_mismatch($sformatf("read_data 0x%02h, predicted 0x%02h",
                                                out_if.read_data, want));
                end
            end
        end
    end

    initial begin
        t_row     row;
        t_setting s;
        err_cnt  = 0;
        quiet    = 1'b0;
        hold_req = 1'b0;

        // State and registers as the block holds them after reset.
        port_mode        = MODE_RESET;
        strobe_timeout   = TIMEOUT_RESET;
        joy_thresh       = THRESH_RESET;
        port_phase       = PH_YL1;
        samp_x           = '0;
        samp_y           = '0;
        acc_x            = 0;
        acc_y            = 0;
        port_status      = STATUS_RESET;
        last_strobe_time = '0;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= '0;
        cfg_data           <= '0;
        in_if.valid        <= 1'b0;
        in_if.op           <= OP_UPDATE;
        in_if.delta_x      <= '0;
        in_if.delta_y      <= '0;
        in_if.press_mask   <= '0;
        in_if.release_mask <= '0;
        in_if.write_value  <= '0;
        in_if.time_now     <= '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, mouse mode at the reset settings. The read right
        // after reset sees phase 7 with empty samples and both buttons up.
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h30));
        // Full-scale movement twice: the second add saturates both axes.
        // Both buttons go down.
        dir_tab.push_back(word_row(make_word(OP_UPDATE, 32767, -32768, 3, 0, 0, 0), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_UPDATE, 32767, -32768, 0, 0, 0, 0), 0, 0));
        // Leaving phase 7 latches the deltas clamped to +127 and -127.
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'h04, 100), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h07));
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'hFB, 200), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h0F));
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'hFF, 300), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h08));
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'h00, 400), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h01));
        // Leaving phase 3 zeroes both samples.
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'h04, 500), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h00));
        // Press and release of button A on one word: the release wins.
        dir_tab.push_back(word_row(make_word(OP_UPDATE, 0, 0, 1, 1, 0, 0), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h10));
        // A gap one past the timeout forces phase 7.
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'h00, 2001), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h10));
        // The unused op with every field at its top changes nothing.
        dir_tab.push_back(word_row(make_word(OP_NONE, -1, -1, 3, 3, 8'hFF, 32'hFFFFFFFF),
                                   0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h10));
        // A gap of exactly the timeout keeps the sequence going.
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'h04, 3501), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h17));
        // Joystick mode: writes are ignored, reads give direction bits.
        dir_tab.push_back(cfg_row(CFG_MODE, 16'd0));
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'h04, 0), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h19));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h10));
        dir_tab.push_back(word_row(make_word(OP_UPDATE, -300, 100, 2, 0, 0, 0), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 1, 6'h14));
        // Back in mouse mode the stale direction bits join the nibble, and
        // the ignored write must not have moved the strobe timestamp.
        dir_tab.push_back(cfg_row(CFG_MODE, 16'd1));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_WRITE, 0, 0, 0, 0, 8'h00, 5001), 0, 0));
        dir_tab.push_back(word_row(make_word(OP_READ, 0, 0, 0, 0, 0, 0), 0, 0));

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.is_cfg) begin
                settle_port();
                write_reg(row.reg_idx, row.reg_val);
                cfg_we <= 1'b0;
            end else begin
                push_word(row.w, row.typed, row.want);
            end
        end

        // Random part: a run of phases, each with its own register setting,
        // the extremes among them. The host clock starts just short of its
        // wrap so strobe gaps are seen across the wrap.
        now_us = 32'hFFFF_F000;
        plan.push_back('{1'b1, 16'd0, 8'd0, 1'b0, 1'b0});
        plan.push_back('{1'b1, 16'd65535, 8'd255, 1'b1, 1'b0});
        plan.push_back('{1'b0, 16'd1500, 8'd0, 1'b0, 1'b0});
        plan.push_back('{1'b0, 16'd1500, 8'd255, 1'b0, 1'b0});
        plan.push_back('{1'b1, 16'd200, 8'd2, 1'b0, 1'b1});
        plan.push_back('{1'b0, 16'd65535, 8'd3, 1'b0, 1'b0});
        plan.push_back('{1'b1, 16'($urandom()), 8'($urandom()), 1'b0, 1'b0});
        plan.push_back('{1'b0, 16'($urandom()), 8'($urandom()), 1'b0, 1'b0});
        plan.push_back('{1'b1, 16'd1500, 8'd2, 1'b0, 1'b0});

        foreach (plan[i]) begin
            s = plan[i];
            settle_port();
            write_reg(CFG_MODE, {15'h0, s.mode});
            write_reg(CFG_TIMEOUT, s.timeout);
            write_reg(CFG_THRESH, {8'h0, s.thresh});
            cfg_we   <= 1'b0;
            quiet    = s.quiet;
            hold_req = s.hold;
            run_random(205);
            quiet = 1'b0;
        end

        settle_port();
        repeat (10) @(negedge i_clk);
        if (pending_reads.size() != 0)
            note_mismatch($sformatf("%0d read results never arrived", pending_reads.size()));

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
design/smnp_pkg.sv
design/smnp_in_if.sv
design/smnp_out_if.sv
design/smnp_cfg.sv
design/smnp_in_reg.sv
design/smnp_core.sv
design/strobed_mouse_nibble_port.sv
test/strobed_mouse_nibble_port_tb.sv
